### rtl/src_pkg.sv
// Shared types, constants and helpers for the sensor reading compensation unit.
// No dependencies; every rtl file imports this package.
package src_pkg;

    localparam int unsigned RawTempW  = 20;
    localparam int unsigned RawPressW = 20;
    localparam int unsigned RawHumW   = 16;
    localparam int unsigned HumOutW   = 17;
    localparam int unsigned CfgAddrW  = 3;
    localparam int unsigned CfgDataW  = 64;
    localparam int unsigned DivSteps  = 32;

    localparam logic [CfgAddrW-1:0] REG_TEMP_CALIB    = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_PRESS_CALIB_A = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_PRESS_CALIB_B = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_PRESS_CALIB_C = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_HUM_CALIB_A   = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_HUM_CALIB_B   = 3'd5;

    localparam logic [31:0] K_PRESS_OFS  = 32'd64000;
    localparam logic [31:0] K_PRESS_FULL = 32'd1048576;
    localparam logic [31:0] K_PRESS_MUL  = 32'd3125;
    localparam logic [31:0] K_PRESS_ONE  = 32'd32768;
    localparam logic [31:0] K_HUM_OFS    = 32'd76800;
    localparam logic [31:0] K_HUM_RND    = 32'd16384;
    localparam logic [31:0] K_HUM_BIAS   = 32'd2097152;
    localparam logic [31:0] K_HUM_RND2   = 32'd8192;
    localparam logic [31:0] K_HUM_MAX    = 32'd419430400;

    // Calibration words, each widened to a 32-bit word as the formulas use it.
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } t_calib;

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
        logic signed [31:0] t;
        t = $signed(x) >>> s;
        return $unsigned(t);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic t_calib unpack_calib(
        input logic [47:0] tc, input logic [63:0] pa, input logic [63:0] pb,
        input logic [15:0] pc, input logic [31:0] ha, input logic [39:0] hb);
        t_calib c;
        c.t1 = {16'd0, tc[15:0]};
        c.t2 = sx16(tc[31:16]);
        c.t3 = sx16(tc[47:32]);
        c.p1 = {16'd0, pa[15:0]};
        c.p2 = sx16(pa[31:16]);
        c.p3 = sx16(pa[47:32]);
        c.p4 = sx16(pa[63:48]);
        c.p5 = sx16(pb[15:0]);
        c.p6 = sx16(pb[31:16]);
        c.p7 = sx16(pb[47:32]);
        c.p8 = sx16(pb[63:48]);
        c.p9 = sx16(pc);
        c.h1 = {24'd0, ha[7:0]};
        c.h2 = sx16(ha[23:8]);
        c.h3 = {24'd0, ha[31:24]};
        c.h4 = sx16(hb[15:0]);
        c.h5 = sx16(hb[31:16]);
        c.h6 = {{24{hb[39]}}, hb[39:32]};
        return c;
    endfunction

endpackage

### rtl/sensor_reading_compensation_unit.sv
// Sensor reading compensation unit: 32-bit integer temperature, pressure and
// humidity compensation with factory calibration words.
//
// Input stream: one raw reading per transfer, tdata holds raw temperature (20 bits),
// raw pressure (20 bits) and raw humidity (16 bits). Output stream: one compensated
// reading per transfer, tdata holds temperature in 0.01 degC, pressure in Pa and
// humidity in %RH * 1024; tuser flags a zero pressure divisor (pressure then 0).
// Calibration registers are loaded through the write port (enable, index, data);
// the user must load them only while no reading is in flight, not enforced by the
// block; indexes beyond the last register are ignored. The 32-stage pressure
// divider is most of the pipeline. Throughput is one reading per cycle without stalls.
// The whole pipeline advances as one unit: when the output holds a result that
// the receiver does not take, every stage and the input ready hold, and nothing
// is lost or repeated. Synchronous active-low reset empties the pipeline and
// clears the calibration registers to zero.
module sensor_reading_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // temperature reading [19:0], pressure reading [39:20], humidity reading [55:40]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // temperature_centi [31:0], pressure_pa [63:32], humidity_q10 [80:64], zero [87:81]
    output logic [87:0] o_m_axis_tdata,
    // pressure_div_zero [0]
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [src_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [src_pkg::CfgDataW-1:0] i_cfg_wdata
);
    import src_pkg::*;

    // 9 front stages, the divider, 3 correction stages
    localparam int unsigned Latency = DivSteps + 12;

    logic [47:0] r_temp_calib;
    logic [63:0] r_press_a, r_press_b;
    logic [15:0] r_press_c;
    logic [31:0] r_hum_a;
    logic [39:0] r_hum_b;
    t_calib      cal;

    logic        en;
    logic        r_vld [0:Latency];
    logic [19:0] r_rt, r_rp;
    logic [15:0] r_rh;

    logic [31:0] fine, temp4, dvd, den, quo, press;
    logic        hi, dz9, dz_out;
    logic [16:0] hum10;

    logic [31:0] r_tdly [0:Latency-5];
    logic [16:0] r_hdly [0:Latency-11];
    logic        r_hidly [0:DivSteps-1];
    logic        r_dzdly [0:DivSteps-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_a    <= '0;
            r_press_b    <= '0;
            r_press_c    <= '0;
            r_hum_a      <= '0;
            r_hum_b      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TEMP_CALIB:    r_temp_calib <= i_cfg_wdata[47:0];
                REG_PRESS_CALIB_A: r_press_a    <= i_cfg_wdata;
                REG_PRESS_CALIB_B: r_press_b    <= i_cfg_wdata;
                REG_PRESS_CALIB_C: r_press_c    <= i_cfg_wdata[15:0];
                REG_HUM_CALIB_A:   r_hum_a      <= i_cfg_wdata[31:0];
                REG_HUM_CALIB_B:   r_hum_b      <= i_cfg_wdata[39:0];
                default: ;
            endcase
        end
    end

    assign cal = unpack_calib(r_temp_calib, r_press_a, r_press_b, r_press_c,
                              r_hum_a, r_hum_b);

    // advance everything unless a finished result is held
    assign en              = !r_vld[Latency] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Latency; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k <= Latency; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt <= i_s_axis_tdata[19:0];
            r_rp <= i_s_axis_tdata[39:20];
            r_rh <= i_s_axis_tdata[55:40];
            r_tdly[0]  <= temp4;
            for (int k = 1; k <= Latency - 5; k++) r_tdly[k] <= r_tdly[k-1];
            r_hdly[0]  <= hum10;
            for (int k = 1; k <= Latency - 11; k++) r_hdly[k] <= r_hdly[k-1];
            r_hidly[0] <= hi;
            r_dzdly[0] <= dz9;
            for (int k = 1; k < DivSteps; k++) begin
                r_hidly[k] <= r_hidly[k-1];
                r_dzdly[k] <= r_dzdly[k-1];
            end
        end
    end

    src_front u_front (
        .i_clk (i_clk), .i_en (en), .i_cal (cal), .i_rt (r_rt), .i_rp (r_rp),
        .o_fine (fine), .o_temp (temp4), .o_dvd (dvd), .o_den (den),
        .o_hi (hi), .o_dz (dz9)
    );

    src_div u_div (
        .i_clk (i_clk), .i_en (en), .i_dvd (dvd), .i_den (den), .o_quo (quo)
    );

    src_press_post u_post (
        .i_clk (i_clk), .i_en (en), .i_cal (cal), .i_quo (quo),
        .i_hi (r_hidly[DivSteps-1]), .i_dz (r_dzdly[DivSteps-1]), .o_press (press),
        .o_dz (dz_out)
    );

    src_hum u_hum (
        .i_clk (i_clk), .i_en (en), .i_cal (cal), .i_rh (r_rh), .i_fine (fine),
        .o_hum (hum10)
    );

    assign o_m_axis_tvalid = r_vld[Latency];
    assign o_m_axis_tdata  = {7'd0, r_hdly[Latency-11], press, r_tdly[Latency-5]};
    assign o_m_axis_tuser  = dz_out;
endmodule

### rtl/src_front.sv
// Temperature and pressure front pipeline: fine temperature, temperature output,
// pressure dividend and divisor. Depends on src_pkg.
module src_front (
    input  logic           i_clk,
    input  logic           i_en,
    input  src_pkg::t_calib i_cal,
    input  logic [19:0]    i_rt,
    input  logic [19:0]    i_rp,
    output logic [31:0]    o_fine,
    output logic [31:0]    o_temp,
    output logic [31:0]    o_dvd,
    output logic [31:0]    o_den,
    output logic           o_hi,
    output logic           o_dz
);
    import src_pkg::*;

    logic [31:0] r1_ma, r1_mdd, r2_a, r2_mb, r3_fine, r4_temp, r4_pa;
    logic [31:0] r5_sq, r5_m5, r5_m2, r6_bq, r6_c3, r6_m5, r6_m2;
    logic [31:0] r7_b, r7_a, r8_pa1, r8_num0, r9_den, r9_dvd;
    logic        r9_hi;
    logic [19:0] r_rp [1:8];
    logic [31:0] n_x1, n_d, n_pa4, n_press0, n_fsum;

    always_comb begin
        n_x1     = {15'd0, i_rt[19:3]} - {i_cal.t1[30:0], 1'b0};
        n_d      = {16'd0, i_rt[19:4]} - i_cal.t1;
        n_pa4    = asr(r4_pa, 2);
        n_press0 = mul32(r8_num0, K_PRESS_MUL);
        n_fsum   = mul32(r3_fine, 32'd5) + 32'd128;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rp[1] <= i_rp;
            for (int k = 2; k <= 8; k++) r_rp[k] <= r_rp[k-1];
            // temperature
            r1_ma   <= mul32(n_x1, i_cal.t2);
            r1_mdd  <= mul32(n_d, n_d);
            r2_a    <= asr(r1_ma, 11);
            r2_mb   <= mul32(asr(r1_mdd, 12), i_cal.t3);
            r3_fine <= r2_a + asr(r2_mb, 14);
            r4_temp <= asr(n_fsum, 8);
            r4_pa   <= asr(r3_fine, 1) - K_PRESS_OFS;
            // pressure offset and divisor
            r5_sq   <= mul32(n_pa4, n_pa4);
            r5_m5   <= mul32(r4_pa, i_cal.p5);
            r5_m2   <= mul32(i_cal.p2, r4_pa);
            r6_bq   <= mul32(asr(r5_sq, 11), i_cal.p6);
            r6_c3   <= mul32(i_cal.p3, asr(r5_sq, 13));
            r6_m5   <= r5_m5;
            r6_m2   <= r5_m2;
            r7_b    <= asr(r6_bq + {r6_m5[30:0], 1'b0}, 2) + {i_cal.p4[15:0], 16'd0};
            r7_a    <= asr(asr(r6_c3, 3) + asr(r6_m2, 1), 18);
            r8_pa1  <= mul32(K_PRESS_ONE + r7_a, i_cal.p1);
            r8_num0 <= (K_PRESS_FULL - {12'd0, r_rp[7]}) - asr(r7_b, 12);
            r9_den  <= asr(r8_pa1, 15);
            r9_hi   <= n_press0[31];
            r9_dvd  <= n_press0[31] ? n_press0 : {n_press0[30:0], 1'b0};
        end
    end

    assign o_fine = r3_fine;
    assign o_temp = r4_temp;
    assign o_dvd  = r9_dvd;
    assign o_den  = r9_den;
    assign o_hi   = r9_hi;
    assign o_dz   = (r9_den == 32'd0);
endmodule

### rtl/src_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on src_pkg.
module src_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_dvd,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo
);
    import src_pkg::*;

    logic [31:0] r_rem [0:DivSteps-1];
    logic [31:0] r_dvd [0:DivSteps-1];
    logic [31:0] r_den [0:DivSteps-1];
    logic [31:0] r_quo [0:DivSteps-1];
    logic [31:0] n_rem [0:DivSteps-1];
    logic [31:0] n_quo [0:DivSteps-1];

    always_comb begin
        for (int k = 0; k < DivSteps; k++) begin
            logic [32:0] sh;
            logic [31:0] rem_in, dvd_in, den_in, quo_in;
            rem_in = (k == 0) ? 32'd0 : r_rem[k-1];
            dvd_in = (k == 0) ? i_dvd : r_dvd[k-1];
            den_in = (k == 0) ? i_den : r_den[k-1];
            quo_in = (k == 0) ? 32'd0 : r_quo[k-1];
            sh = {rem_in, dvd_in[31]};
            if (sh >= {1'b0, den_in}) begin
                n_rem[k] = 32'(sh - {1'b0, den_in});
                n_quo[k] = {quo_in[30:0], 1'b1};
            end else begin
                n_rem[k] = sh[31:0];
                n_quo[k] = {quo_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DivSteps; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= (k == 0) ? i_den : r_den[k-1];
                r_dvd[k] <= (k == 0) ? {i_dvd[30:0], 1'b0} : {r_dvd[k-1][30:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo[DivSteps-1];
endmodule

### rtl/src_press_post.sv
// Pressure correction after the divide: second-order terms and zero-divisor result.
// Depends on src_pkg.
module src_press_post (
    input  logic            i_clk,
    input  logic            i_en,
    input  src_pkg::t_calib i_cal,
    input  logic [31:0]     i_quo,
    input  logic            i_hi,
    input  logic            i_dz,
    output logic [31:0]     o_press,
    output logic            o_dz
);
    import src_pkg::*;

    logic [31:0] n_p, r1_p, r1_sq, r1_mb, r2_p, r2_ma, r2_mb, r3_press;
    logic        r1_dz, r2_dz, r3_dz;

    assign n_p = i_hi ? {i_quo[30:0], 1'b0} : i_quo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p     <= n_p;
            r1_sq    <= mul32({3'd0, n_p[31:3]}, {3'd0, n_p[31:3]});
            r1_mb    <= mul32({2'd0, n_p[31:2]}, i_cal.p8);
            r1_dz    <= i_dz;
            r2_p     <= r1_p;
            r2_ma    <= mul32(i_cal.p9, {13'd0, r1_sq[31:13]});
            r2_mb    <= r1_mb;
            r2_dz    <= r1_dz;
            // zero divisor gives zero pressure
            r3_press <= r2_dz ? 32'd0
                      : r2_p + asr(asr(r2_ma, 12) + asr(r2_mb, 13) + i_cal.p7, 4);
            r3_dz    <= r2_dz;
        end
    end

    assign o_press = r3_press;
    assign o_dz    = r3_dz;
endmodule

### rtl/src_hum.sv
// Humidity pipeline: takes fine temperature and raw humidity, gives clamped %RH * 1024.
// Depends on src_pkg.
module src_hum (
    input  logic            i_clk,
    input  logic            i_en,
    input  src_pkg::t_calib i_cal,
    input  logic [15:0]     i_rh,
    input  logic [31:0]     i_fine,
    output logic [16:0]     o_hum
);
    import src_pkg::*;

    logic [15:0] r_rh [1:4];
    logic [31:0] n_v, r4_mh5, r4_mh3, r4_mh6;
    logic [31:0] r5_ah, r5_tu, r6_ah, r6_mh2, r7_v, r8_v, r8_qq, r9_v, r9_mm;
    logic [31:0] n_q, n_v2;
    logic [16:0] r10_hum;

    always_comb begin
        n_v  = i_fine - K_HUM_OFS;
        n_q  = asr(r7_v, 15);
        n_v2 = r9_v - asr(r9_mm, 4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rh[1] <= i_rh;
            for (int k = 2; k <= 4; k++) r_rh[k] <= r_rh[k-1];
            r4_mh5 <= mul32(i_cal.h5, n_v);
            r4_mh3 <= mul32(n_v, i_cal.h3);
            r4_mh6 <= mul32(n_v, i_cal.h6);
            r5_ah  <= asr((({2'd0, r_rh[4], 14'd0} - {i_cal.h4[11:0], 20'd0}) - r4_mh5)
                          + K_HUM_RND, 15);
            r5_tu  <= mul32(asr(r4_mh3, 11) + K_PRESS_ONE, asr(r4_mh6, 10));
            r6_ah  <= r5_ah;
            r6_mh2 <= mul32(asr(r5_tu, 10) + K_HUM_BIAS, i_cal.h2);
            r7_v   <= mul32(r6_ah, asr(r6_mh2 + K_HUM_RND2, 14));
            r8_v   <= r7_v;
            r8_qq  <= mul32(n_q, n_q);
            r9_v   <= r8_v;
            r9_mm  <= mul32(asr(r8_qq, 7), i_cal.h1);
            // clamp to 0..100 %RH before scaling
            if (n_v2[31])
                r10_hum <= '0;
            else if (n_v2 > K_HUM_MAX)
                r10_hum <= K_HUM_MAX[28:12];
            else
                r10_hum <= n_v2[28:12];
        end
    end

    assign o_hum = r10_hum;
endmodule

### rtl/src_checker.sv
// Port-level checks for sensor_reading_compensation_unit, bound to the top level.
// Depends on src_pkg.
module src_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);
    import src_pkg::*;

    // a held result stays in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output transfer changed while stalled");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[63:32] == 32'd0)
        else $error("pressure not zero on zero divisor");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[80:64] <= 17'd102400 &&
                            o_m_axis_tdata[87:81] == 7'd0)
        else $error("humidity out of range");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid || i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled with output free");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind sensor_reading_compensation_unit src_checker u_src_checker (
    .i_clk (i_clk), .i_rst_n (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready), .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready), .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
